// ===== rtl/hptc_pkg.sv =====
package hptc_pkg;

  localparam logic [2:0] REG_TEMP_COEFFS = 3'd0;
  localparam logic [2:0] REG_PRESS_A     = 3'd1;
  localparam logic [2:0] REG_PRESS_B     = 3'd2;
  localparam logic [2:0] REG_PRESS_NINE  = 3'd3;
  localparam logic [2:0] REG_HUM_COEFFS  = 3'd4;
  localparam logic [2:0] REG_HAS_HUM     = 3'd5;

  localparam logic [31:0] FINE_OFFSET_P = 32'd64000;
  localparam logic [31:0] PRESS_FULL    = 32'd1048576;
  localparam logic [31:0] PRESS_SCALE   = 32'd3125;
  localparam logic [31:0] FINE_OFFSET_H = 32'd76800;
  localparam logic [31:0] HUM_ROUND     = 32'd16384;
  localparam logic [31:0] HUM_ONE       = 32'd32768;
  localparam logic [31:0] HUM_BIAS      = 32'd2097152;
  localparam logic [31:0] HUM_ROUND2    = 32'd8192;
  localparam logic [31:0] HUM_MAX       = 32'd419430400;

  function automatic logic [31:0] asr(input logic [31:0] x, input int unsigned n);
    logic signed [31:0] s;
    s = $signed(x);
    return $unsigned(s >>> n);
  endfunction

  function automatic logic [31:0] sx16(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  function automatic logic [31:0] sx12(input logic [11:0] v);
    return {{20{v[11]}}, v};
  endfunction

  function automatic logic [31:0] sx8(input logic [7:0] v);
    return {{24{v[7]}}, v};
  endfunction

endpackage

// ===== rtl/humidity_pressure_temp_compensation.sv =====
// Compensates one raw pressure/temperature/humidity triple per clock. A request is
// taken whenever start is high (busy stays low), and its result appears on the result
// ports with done high for one cycle; results leave in request order and cannot be
// held off. The latency is set by the pressure path: the fine temperature (3 stages),
// the pressure divisor and numerator (5 stages), a 32-stage one-bit-per-stage divider
// and 4 stages of final correction. Coefficients may only be written while no request
// is in flight; cfg_ready is always high.
module humidity_pressure_temp_compensation (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [19:0] raw_pressure,
  input  logic [19:0] raw_temperature,
  input  logic [15:0] raw_humidity,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  output logic        done,
  output logic signed [31:0] temp_centideg,
  output logic [31:0] pressure_pa,
  output logic        pressure_valid,
  output logic [16:0] humidity_q10
);

  localparam int unsigned LAT = 44;

  logic [47:0] temp_coeffs;
  logic [63:0] press_coeffs_a, press_coeffs_b, hum_coeffs;
  logic [15:0] press_coeff_nine;
  logic        has_humidity;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      temp_coeffs      <= '0;
      press_coeffs_a   <= '0;
      press_coeffs_b   <= '0;
      press_coeff_nine <= '0;
      hum_coeffs       <= '0;
      has_humidity     <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        hptc_pkg::REG_TEMP_COEFFS: temp_coeffs      <= cfg_data[47:0];
        hptc_pkg::REG_PRESS_A:     press_coeffs_a   <= cfg_data;
        hptc_pkg::REG_PRESS_B:     press_coeffs_b   <= cfg_data;
        hptc_pkg::REG_PRESS_NINE:  press_coeff_nine <= cfg_data[15:0];
        hptc_pkg::REG_HUM_COEFFS:  hum_coeffs       <= cfg_data;
        hptc_pkg::REG_HAS_HUM:     has_humidity     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Stage 0: request capture.
  logic        in_v;
  logic [19:0] in_p, in_t;
  logic [15:0] in_h;
  logic [LAT-1:0] vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_v <= 1'b0;
      vld  <= '0;
    end else begin
      in_v <= start && !busy;
      vld  <= {vld[LAT-2:0], in_v};
    end
  end

  always_ff @(posedge clk) begin
    in_p <= raw_pressure;
    in_t <= raw_temperature;
    in_h <= raw_humidity;
  end

  assign done = vld[LAT-1];

  // Fine temperature at stage 3, temperature at stage 4.
  logic [31:0] fine, temp;
  hptc_fine u_fine (
    .clk         (clk),
    .adc_t       (in_t),
    .temp_coeffs (temp_coeffs),
    .fine        (fine),
    .temp        (temp)
  );

  // Humidity from stage 3 to stage 10.
  logic [15:0] h_dly [3];
  logic [16:0] hum;
  always_ff @(posedge clk) begin
    h_dly[0] <= in_h;
    for (int i = 1; i < 3; i++) h_dly[i] <= h_dly[i-1];
  end

  hptc_hum u_hum (
    .clk          (clk),
    .fine         (fine),
    .adc_h        (h_dly[2]),
    .hum_coeffs   (hum_coeffs),
    .has_humidity (has_humidity),
    .hum          (hum)
  );

  // Pressure divisor and numerator, stages 4 to 8.
  logic [31:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
  assign p1 = {16'd0, press_coeffs_a[15:0]};
  assign p2 = hptc_pkg::sx16(press_coeffs_a[31:16]);
  assign p3 = hptc_pkg::sx16(press_coeffs_a[47:32]);
  assign p4 = hptc_pkg::sx16(press_coeffs_a[63:48]);
  assign p5 = hptc_pkg::sx16(press_coeffs_b[15:0]);
  assign p6 = hptc_pkg::sx16(press_coeffs_b[31:16]);
  assign p7 = hptc_pkg::sx16(press_coeffs_b[47:32]);
  assign p8 = hptc_pkg::sx16(press_coeffs_b[63:48]);
  assign p9 = hptc_pkg::sx16(press_coeff_nine);

  logic [19:0] p_dly [7];
  always_ff @(posedge clk) begin
    p_dly[0] <= in_p;
    for (int i = 1; i < 7; i++) p_dly[i] <= p_dly[i-1];
  end

  logic [31:0] a4, qq4, q4_q;
  logic [31:0] b1_5, a5_5, m3_5, m2_5;
  logic [31:0] b6, s6;
  logic [31:0] am7, pb7;
  logic [31:0] den8, num8;
  logic        mode8;

  assign q4_q = hptc_pkg::asr(hptc_pkg::asr(fine, 1) - hptc_pkg::FINE_OFFSET_P, 2);

  always_ff @(posedge clk) begin
    a4   <= hptc_pkg::asr(fine, 1) - hptc_pkg::FINE_OFFSET_P;
    qq4  <= q4_q * q4_q;
    b1_5 <= hptc_pkg::asr(qq4, 11) * p6;
    a5_5 <= a4 * p5;
    m3_5 <= p3 * hptc_pkg::asr(qq4, 13);
    m2_5 <= p2 * a4;
    b6   <= hptc_pkg::asr(b1_5 + {a5_5[30:0], 1'b0}, 2) + {p4[15:0], 16'd0};
    s6   <= hptc_pkg::HUM_ONE
            + hptc_pkg::asr(hptc_pkg::asr(m3_5, 3) + hptc_pkg::asr(m2_5, 1), 18);
    am7  <= s6 * p1;
    pb7  <= hptc_pkg::asr(b6, 12);
    den8 <= hptc_pkg::asr(am7, 15);
    num8 <= ((hptc_pkg::PRESS_FULL - {12'd0, p_dly[6]}) - pb7) * hptc_pkg::PRESS_SCALE;
  end

  // Below half range the numerator is doubled before the divide, else the quotient is.
  assign mode8 = num8[31];

  logic [31:0] quo40;
  hptc_div u_div (
    .clk      (clk),
    .dividend (mode8 ? num8 : {num8[30:0], 1'b0}),
    .divisor  (den8),
    .quotient (quo40)
  );

  logic [1:0] f_dly [35];
  always_ff @(posedge clk) begin
    f_dly[0] <= {mode8, den8 != 32'd0};
    for (int i = 1; i < 35; i++) f_dly[i] <= f_dly[i-1];
  end

  // Final correction, stages 41 to 44.
  logic [31:0] p41, p42, c42, e42, p43, c43, e43;
  logic [31:0] press44;
  logic        ok44;

  always_ff @(posedge clk) begin
    p41     <= f_dly[31][1] ? {quo40[30:0], 1'b0} : quo40;
    p42     <= p41;
    c42     <= {3'd0, p41[31:3]} * {3'd0, p41[31:3]};
    e42     <= {2'd0, p41[31:2]} * p8;
    p43     <= p42;
    c43     <= {13'd0, c42[31:13]} * p9;
    e43     <= hptc_pkg::asr(e42, 13);
    press44 <= f_dly[34][0]
               ? p43 + hptc_pkg::asr(hptc_pkg::asr(c43, 12) + e43 + p7, 4) : 32'd0;
    ok44    <= f_dly[34][0];
  end

  // Align temperature and humidity with the pressure result.
  logic [31:0] t_dly [40];
  logic [16:0] hu_dly [34];
  always_ff @(posedge clk) begin
    t_dly[0]  <= temp;
    hu_dly[0] <= hum;
    for (int i = 1; i < 40; i++) t_dly[i] <= t_dly[i-1];
    for (int i = 1; i < 34; i++) hu_dly[i] <= hu_dly[i-1];
  end

  assign temp_centideg  = $signed(t_dly[39]);
  assign pressure_pa    = press44;
  assign pressure_valid = ok44;
  assign humidity_q10   = hu_dly[33];

endmodule

// ===== rtl/hptc_fine.sv =====
module hptc_fine (
  input  logic        clk,
  input  logic [19:0] adc_t,
  input  logic [47:0] temp_coeffs,
  output logic [31:0] fine,
  output logic [31:0] temp
);

  logic [31:0] t1, t2, t3;
  logic [31:0] v1m, dd, v1, v2m;

  assign t1 = {16'd0, temp_coeffs[15:0]};
  assign t2 = hptc_pkg::sx16(temp_coeffs[31:16]);
  assign t3 = hptc_pkg::sx16(temp_coeffs[47:32]);

  always_ff @(posedge clk) begin
    v1m  <= ({15'd0, adc_t[19:3]} - {15'd0, temp_coeffs[15:0], 1'b0}) * t2;
    dd   <= ({16'd0, adc_t[19:4]} - t1) * ({16'd0, adc_t[19:4]} - t1);
    v1   <= hptc_pkg::asr(v1m, 11);
    v2m  <= hptc_pkg::asr(dd, 12) * t3;
    fine <= v1 + hptc_pkg::asr(v2m, 14);
    // fine * 5 as shift and add, rounded by the constant 128.
    temp <= hptc_pkg::asr({fine[29:0], 2'b00} + fine + 32'd128, 8);
  end

endmodule

// ===== rtl/hptc_hum.sv =====
module hptc_hum (
  input  logic        clk,
  input  logic [31:0] fine,
  input  logic [15:0] adc_h,
  input  logic [63:0] hum_coeffs,
  input  logic        has_humidity,
  output logic [16:0] hum
);

  logic [31:0] h1, h2, h3, h4, h5, h6, h_d;
  logic [31:0] xs, m5, m6, m3;
  logic [31:0] x2, y1;
  logic [31:0] x3, y2m;
  logic [31:0] v4;
  logic [31:0] v5, ss;
  logic [31:0] v6, t6;
  logic [31:0] v7;

  assign h1 = {24'd0, hum_coeffs[7:0]};
  assign h2 = hptc_pkg::sx16(hum_coeffs[23:8]);
  assign h3 = {24'd0, hum_coeffs[31:24]};
  assign h4 = hptc_pkg::sx12(hum_coeffs[43:32]);
  assign h5 = hptc_pkg::sx12(hum_coeffs[55:44]);
  assign h6 = hptc_pkg::sx8(hum_coeffs[63:56]);
  assign h_d = fine - hptc_pkg::FINE_OFFSET_H;

  assign v7 = v6 - hptc_pkg::asr(t6, 4);

  always_ff @(posedge clk) begin
    xs  <= {2'd0, adc_h, 14'd0} - {h4[11:0], 20'd0} + hptc_pkg::HUM_ROUND;
    m5  <= h5 * h_d;
    m6  <= h_d * h6;
    m3  <= h_d * h3;
    x2  <= hptc_pkg::asr(xs - m5, 15);
    y1  <= hptc_pkg::asr(m6, 10) * (hptc_pkg::asr(m3, 11) + hptc_pkg::HUM_ONE);
    x3  <= x2;
    y2m <= (hptc_pkg::asr(y1, 10) + hptc_pkg::HUM_BIAS) * h2;
    v4  <= x3 * hptc_pkg::asr(y2m + hptc_pkg::HUM_ROUND2, 14);
    v5  <= v4;
    ss  <= hptc_pkg::asr(v4, 15) * hptc_pkg::asr(v4, 15);
    v6  <= v5;
    t6  <= hptc_pkg::asr(ss, 7) * h1;
    // Clamp to 0..100 %RH before dropping the low fraction bits.
    if (!has_humidity || v7[31]) begin
      hum <= 17'd0;
    end else if (v7 > hptc_pkg::HUM_MAX) begin
      hum <= hptc_pkg::HUM_MAX[28:12];
    end else begin
      hum <= v7[28:12];
    end
  end

endmodule

// ===== rtl/hptc_div.sv =====
module hptc_div (
  input  logic        clk,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  output logic [31:0] quotient
);

  // One restoring step per stage; a zero divisor yields all ones.
  logic [31:0] rem [32];
  logic [31:0] quo [32];
  logic [31:0] dvd [32];
  logic [31:0] dsr [32];

  function automatic logic step_fit(input logic [31:0] r, input logic b, input logic [31:0] d);
    return {r, b} >= {1'b0, d};
  endfunction

  function automatic logic [31:0] step_rem(input logic [31:0] r, input logic b,
                                           input logic [31:0] d);
    logic [32:0] trial;
    trial = {r, b};
    return (trial >= {1'b0, d}) ? 32'(trial - {1'b0, d}) : trial[31:0];
  endfunction

  always_ff @(posedge clk) begin
    rem[0] <= step_rem(32'd0, dividend[31], divisor);
    quo[0] <= {31'd0, step_fit(32'd0, dividend[31], divisor)};
    dvd[0] <= {dividend[30:0], 1'b0};
    dsr[0] <= divisor;
    for (int i = 1; i < 32; i++) begin
      rem[i] <= step_rem(rem[i-1], dvd[i-1][31], dsr[i-1]);
      quo[i] <= {quo[i-1][30:0], step_fit(rem[i-1], dvd[i-1][31], dsr[i-1])};
      dvd[i] <= {dvd[i-1][30:0], 1'b0};
      dsr[i] <= dsr[i-1];
    end
  end

  assign quotient = quo[31];

endmodule

// ===== sim/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [19:0] press;
    logic [19:0] temp;
    logic [15:0] hum;
  } sample_t;

  typedef struct packed {
    logic [31:0] temp_centideg;
    logic [31:0] pressure_pa;
    logic        pressure_valid;
    logic [16:0] humidity_q10;
  } comp_t;

  localparam int LATENCY = 44;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [19:0] raw_pressure = '0;
  logic [19:0] raw_temperature = '0;
  logic [15:0] raw_humidity = '0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [63:0] cfg_data = '0;
  logic done;
  logic signed [31:0] temp_centideg;
  logic [31:0] pressure_pa;
  logic pressure_valid;
  logic [16:0] humidity_q10;

  humidity_pressure_temp_compensation u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .raw_pressure(raw_pressure), .raw_temperature(raw_temperature),
    .raw_humidity(raw_humidity), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data), .done(done),
    .temp_centideg(temp_centideg), .pressure_pa(pressure_pa),
    .pressure_valid(pressure_valid), .humidity_q10(humidity_q10)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Calibration copy used by the predictor.
  logic [47:0] cal_t;
  logic [63:0] cal_pa, cal_pb, cal_h;
  logic [15:0] cal_p9;
  logic        cal_has_h;

  sample_t samples_pending[$];
  comp_t   expected_comp[$];
  int      n_errors = 0;
  int      n_checked = 0;
  int      n_invalid = 0;
  bit      idle_ok = 1'b1;
  bit      sending = 1'b0;

  function automatic logic [31:0] sra(input logic [31:0] x, input int n);
    logic signed [31:0] s;
    s = x;
    return s >>> n;
  endfunction

  function automatic logic [31:0] sext(input logic [63:0] v, input int w);
    logic [31:0] m;
    logic [31:0] x;
    m = (32'd1 << w) - 1;
    x = v[31:0] & m;
    if (x[w-1]) x = x | ~m;
    return x;
  endfunction

  function automatic comp_t compensate(input sample_t s);
    comp_t r;
    logic [31:0] t1, t2, t3, v1, dt, v2, fine;
    logic [31:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic [31:0] a, q, qq, b, p, c, e;
    logic [31:0] h1, h2, h3, h4, h5, h6, h, x, y, v, sh;
    t1 = {16'd0, cal_t[15:0]};
    t2 = sext(cal_t >> 16, 16);
    t3 = sext(cal_t >> 32, 16);
    v1 = sra(((32'(s.temp) >> 3) - (t1 << 1)) * t2, 11);
    dt = (32'(s.temp) >> 4) - t1;
    v2 = sra(sra(dt * dt, 12) * t3, 14);
    fine = v1 + v2;
    r.temp_centideg = sra(fine * 32'd5 + 32'd128, 8);

    p1 = {16'd0, cal_pa[15:0]};
    p2 = sext(cal_pa >> 16, 16);
    p3 = sext(cal_pa >> 32, 16);
    p4 = sext(cal_pa >> 48, 16);
    p5 = sext(cal_pb, 16);
    p6 = sext(cal_pb >> 16, 16);
    p7 = sext(cal_pb >> 32, 16);
    p8 = sext(cal_pb >> 48, 16);
    p9 = sext({48'd0, cal_p9}, 16);
    a = sra(fine, 1) - hptc_pkg::FINE_OFFSET_P;
    q = sra(a, 2);
    qq = q * q;
    b = sra(qq, 11) * p6;
    b = b + ((a * p5) << 1);
    b = sra(b, 2) + (p4 << 16);
    a = sra(sra(p3 * sra(qq, 13), 3) + sra(p2 * a, 1), 18);
    a = sra((hptc_pkg::HUM_ONE + a) * p1, 15);
    r.pressure_pa = '0;
    r.pressure_valid = 1'b0;
    if (a != 0) begin
      p = ((hptc_pkg::PRESS_FULL - 32'(s.press)) - sra(b, 12)) * hptc_pkg::PRESS_SCALE;
      if (p < 32'h8000_0000) p = (p << 1) / a;
      else p = (p / a) * 32'd2;
      c = sra(p9 * (((p >> 3) * (p >> 3)) >> 13), 12);
      e = sra((p >> 2) * p8, 13);
      r.pressure_pa = p + sra(c + e + p7, 4);
      r.pressure_valid = 1'b1;
    end

    r.humidity_q10 = '0;
    if (cal_has_h) begin
      h1 = {24'd0, cal_h[7:0]};
      h2 = sext(cal_h >> 8, 16);
      h3 = {24'd0, cal_h[31:24]};
      h4 = sext(cal_h >> 32, 12);
      h5 = sext(cal_h >> 44, 12);
      h6 = sext(cal_h >> 56, 8);
      h = fine - hptc_pkg::FINE_OFFSET_H;
      x = sra((32'(s.hum) << 14) - (h4 << 20) - (h5 * h) + hptc_pkg::HUM_ROUND, 15);
      y = sra(sra(h * h6, 10) * (sra(h * h3, 11) + hptc_pkg::HUM_ONE), 10);
      y = sra((y + hptc_pkg::HUM_BIAS) * h2 + hptc_pkg::HUM_ROUND2, 14);
      v = x * y;
      sh = sra(v, 15);
      v = v - sra(sra(sh * sh, 7) * h1, 4);
      if (v[31]) v = '0;
      if (v > hptc_pkg::HUM_MAX) v = hptc_pkg::HUM_MAX;
      r.humidity_q10 = v[28:12];
    end
    return r;
  endfunction

  // Driver: one request per accepted edge, with random idle bursts.
  int gap = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) begin
        expected_comp.push_back(compensate({raw_pressure, raw_temperature, raw_humidity}));
        void'(samples_pending.pop_front());
      end
      if (gap > 0) begin
        gap <= gap - 1;
        start <= 1'b0;
      end else if (sending && idle_ok && $urandom_range(0, 9) == 0) begin
        gap <= $urandom_range(0, 2);
        start <= 1'b0;
      end else begin
        // An accepted head has already been popped above, so the head goes out next.
        if (sending && samples_pending.size() > 0) begin
          sample_t nx;
          nx = samples_pending[0];
          start <= 1'b1;
          raw_pressure <= nx.press;
          raw_temperature <= nx.temp;
          raw_humidity <= nx.hum;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: results are accepted on every edge where done is high.
  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_comp.size() == 0) begin
        $error("unexpected result: temp %0d pressure %0d", temp_centideg, pressure_pa);
        n_errors++;
      end else begin
        comp_t ex;
        ex = expected_comp.pop_front();
        n_checked++;
        if (!ex.pressure_valid) n_invalid++;
        if (temp_centideg !== ex.temp_centideg) begin
          $error("temp_centideg expected %0d actual %0d",
                 $signed(ex.temp_centideg), temp_centideg);
          n_errors++;
        end
        if (pressure_pa !== ex.pressure_pa) begin
          $error("pressure_pa expected %0d actual %0d", ex.pressure_pa, pressure_pa);
          n_errors++;
        end
        if (pressure_valid !== ex.pressure_valid) begin
          $error("pressure_valid expected %0d actual %0d", ex.pressure_valid, pressure_valid);
          n_errors++;
        end
        if (humidity_q10 !== ex.humidity_q10) begin
          $error("humidity_q10 expected %0d actual %0d", ex.humidity_q10, humidity_q10);
          n_errors++;
        end
      end
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      hptc_pkg::REG_TEMP_COEFFS: cal_t = val[47:0];
      hptc_pkg::REG_PRESS_A:     cal_pa = val;
      hptc_pkg::REG_PRESS_B:     cal_pb = val;
      hptc_pkg::REG_PRESS_NINE:  cal_p9 = val[15:0];
      hptc_pkg::REG_HUM_COEFFS:  cal_h = val;
      hptc_pkg::REG_HAS_HUM:     cal_has_h = val[0];
      default: ;
    endcase
  endtask

  // Waits until the queue is drained and the pipeline is empty.
  task automatic drain();
    sending = 1'b0;
    while (samples_pending.size() != 0 || start || expected_comp.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic run(input int n);
    sending = 1'b1;
    while (samples_pending.size() != 0) @(posedge clk);
    drain();
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Coefficients typical of a real part, so pressure lands in a sane range.
  task automatic typical_cal(input bit with_hum);
    write_reg(hptc_pkg::REG_TEMP_COEFFS, {16'hFC18, 16'd26435, 16'd27504});
    write_reg(hptc_pkg::REG_PRESS_A, {16'd2855, 16'hF3A3, 16'hD67D, 16'd36477});
    write_reg(hptc_pkg::REG_PRESS_B, {16'hF6DF, 16'h3A8A, 16'hFFF9, 16'd140});
    write_reg(hptc_pkg::REG_PRESS_NINE, 64'd6000);
    write_reg(hptc_pkg::REG_HUM_COEFFS, {8'd30, 12'd50, 12'd320, 8'd0, 16'd360, 8'd75});
    write_reg(hptc_pkg::REG_HAS_HUM, {63'd0, with_hum});
  endtask

  task automatic add_random(input int n);
    repeat (n) begin
      sample_t s;
      s.press = $urandom_range(0, 3) == 0 ? 20'($urandom()) : 20'($urandom_range(200000, 600000));
      s.temp = $urandom_range(0, 3) == 0 ? 20'($urandom()) : 20'($urandom_range(400000, 600000));
      s.hum = 16'($urandom());
      samples_pending.push_back(s);
    end
  endtask

  initial begin
    cal_t = '0; cal_pa = '0; cal_pb = '0; cal_p9 = '0; cal_h = '0; cal_has_h = 1'b1;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset calibration: divisor is zero, so pressure is flagged invalid.
    samples_pending.push_back('{20'd0, 20'd0, 16'd0});
    samples_pending.push_back('{20'hFFFFF, 20'hFFFFF, 16'hFFFF});
    run(2);

    typical_cal(1'b1);
    samples_pending.push_back('{20'd0, 20'd0, 16'd0});
    samples_pending.push_back('{20'hFFFFF, 20'hFFFFF, 16'hFFFF});
    samples_pending.push_back('{20'd415148, 20'd519888, 16'd30000});
    samples_pending.push_back('{20'h55555, 20'hAAAAA, 16'h5555});
    samples_pending.push_back('{20'hAAAAA, 20'h55555, 16'hAAAA});
    samples_pending.push_back('{20'd415148, 20'd519888, 16'd0});
    samples_pending.push_back('{20'd415148, 20'd519888, 16'd65535});
    run(7);

    typical_cal(1'b0);
    samples_pending.push_back('{20'd415148, 20'd519888, 16'd40000});
    run(1);

    // Extreme coefficients: all ones, then most negative lanes, wrapping freely.
    write_reg(hptc_pkg::REG_TEMP_COEFFS, 64'hFFFF_FFFF_FFFF);
    write_reg(hptc_pkg::REG_PRESS_A, '1);
    write_reg(hptc_pkg::REG_PRESS_B, '1);
    write_reg(hptc_pkg::REG_PRESS_NINE, 64'hFFFF);
    write_reg(hptc_pkg::REG_HUM_COEFFS, '1);
    write_reg(hptc_pkg::REG_HAS_HUM, 64'd1);
    add_random(4);
    samples_pending.push_back('{20'hFFFFF, 20'd0, 16'hFFFF});
    run(5);
    write_reg(hptc_pkg::REG_TEMP_COEFFS, 64'h8000_8000_0000);
    write_reg(hptc_pkg::REG_PRESS_A, 64'h8000_8000_8000_FFFF);
    write_reg(hptc_pkg::REG_PRESS_B, 64'h8000_8000_8000_8000);
    write_reg(hptc_pkg::REG_PRESS_NINE, 64'h8000);
    write_reg(hptc_pkg::REG_HUM_COEFFS, 64'h8080_0800_FF80_00FF);
    add_random(4);
    run(4);

    // Random phases: mostly realistic calibration, some fully random.
    for (int ph = 0; ph < 12; ph++) begin
      if (ph % 3 == 0) begin
        write_reg(hptc_pkg::REG_TEMP_COEFFS, rand64());
        write_reg(hptc_pkg::REG_PRESS_A, rand64());
        write_reg(hptc_pkg::REG_PRESS_B, rand64());
        write_reg(hptc_pkg::REG_PRESS_NINE, rand64());
        write_reg(hptc_pkg::REG_HUM_COEFFS, rand64());
        write_reg(hptc_pkg::REG_HAS_HUM, 64'($urandom_range(0, 1)));
      end else begin
        typical_cal(ph != 4);
      end
      if (ph == 11) idle_ok = 1'b0;
      add_random(110);
      run(110);
    end

    $display("tb_top: %0d results checked over reset, typical, extreme and random calibration,",
             n_checked);
    $display("tb_top: %0d with the pressure divisor at zero", n_invalid);
    if (n_errors == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("tb_top: errors");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/hptc_pkg.sv
rtl/hptc_fine.sv
rtl/hptc_hum.sv
rtl/hptc_div.sv
rtl/humidity_pressure_temp_compensation.sv
sim/tb_top.sv
